### rtl/core/bap_pkg.sv
// Shared types, constants and codes for the bump allocator.
package bap_pkg;

    localparam int PAGE_BYTES_DEF  = 65536;
    localparam int ALIGN_BYTES_DEF = 16;

    localparam logic [31:0] SIZE_CAP       = 32'h7FFF_FFFF;
    localparam logic [31:0] HEAP_START_RST = 32'h0001_0000;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'h0002_0000;
    localparam logic [15:0] INIT_PAGES_RST = 16'd2;
    localparam logic [15:0] MAX_PAGES_RST  = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_MALLOC        = 3'd0,
        OP_MEMALIGN      = 3'd1,
        OP_ALIGNED_ALLOC = 3'd2,
        OP_FREE          = 3'd3,
        OP_REALLOC       = 3'd4,
        OP_CALLOC        = 3'd5,
        OP_REALLOCARRAY  = 3'd6,
        OP_GOOD_SIZE     = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_HEAP_START = 2'd0,
        CFG_HEAP_LIMIT = 2'd1,
        CFG_INIT_PAGES = 2'd2,
        CFG_MAX_PAGES  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        REQ_FAIL,
        REQ_SIZE,
        REQ_FREE,
        REQ_ALLOC,
        REQ_REALLOC
    } req_kind_t;

    typedef struct packed {
        logic        en;
        cfg_idx_t    index;
        logic [31:0] data;
    } cfg_wr_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] address;
        logic [31:0] size;
        logic [31:0] count;
        logic [31:0] alignment;
    } item_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] address;
        logic [31:0] size;
        logic [31:0] alignment;
        logic [31:0] prod;
        logic        prod_ovf;
        logic [32:0] need;
    } mul_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] ptr;
        logic [31:0] raw_size;
        logic [31:0] alloc_sz;
        logic        tiny;
        logic        post_align;
        logic [31:0] align_m1;
        logic [31:0] good;
    } req_t;

    typedef struct packed {
        logic [31:0] result_addr;
        logic        is_null;
        logic [31:0] copy_source;
        logic [31:0] copy_length;
    } result_t;

endpackage

### rtl/core/bap_front.sv
// Input register and element-count multiply stage.
module bap_front #(
    parameter int ALIGN_BYTES = bap_pkg::ALIGN_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bap_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output bap_pkg::mul_t   out_mul
);

    bap_pkg::item_t item_reg;
    logic           item_valid_reg;
    bap_pkg::mul_t  mul_reg;
    logic           mul_valid_reg;

    logic           mul_ready;
    logic [63:0]    prod;
    bap_pkg::mul_t  mul_next;

    assign mul_ready = !mul_valid_reg || out_ready;
    assign in_ready  = !item_valid_reg || mul_ready;

    assign prod = 64'(item_reg.count) * 64'(item_reg.size);

    always_comb begin
        mul_next.opcode    = item_reg.opcode;
        mul_next.address   = item_reg.address;
        mul_next.size      = item_reg.size;
        mul_next.alignment = item_reg.alignment;
        mul_next.prod      = prod[31:0];
        mul_next.prod_ovf  = |prod[63:32];
        mul_next.need      = 33'(item_reg.size) + 33'(item_reg.alignment) - 33'(ALIGN_BYTES);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            mul_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                mul_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
        if (mul_ready && item_valid_reg) begin
            mul_reg <= mul_next;
        end
    end

    assign out_valid = mul_valid_reg;
    assign out_mul   = mul_reg;

endmodule

### rtl/core/bap_prep.sv
// Request decode stage: size checks, rounding and operation classification.
module bap_prep #(
    parameter int ALIGN_BYTES = bap_pkg::ALIGN_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  bap_pkg::mul_t  in_mul,
    output logic           out_valid,
    input  logic           out_ready,
    output bap_pkg::req_t  out_req
);

    localparam logic [31:0] AMASK = 32'(ALIGN_BYTES - 1);

    function automatic logic [31:0] round_al(input logic [31:0] v);
        round_al = (v + AMASK) & ~AMASK;
    endfunction

    function automatic logic size_bad(input logic [31:0] v);
        size_bad = (v == '0) || (v > bap_pkg::SIZE_CAP);
    endfunction

    bap_pkg::req_t req_reg;
    logic          req_valid_reg;
    bap_pkg::req_t req_next;

    logic [31:0] rnd_size;
    logic [31:0] rnd_prod;
    logic [31:0] rnd_need;
    logic [31:0] align_m1;
    logic        bad_size;
    logic        pow2;
    logic        aa_ok;
    logic        big_align;
    logic        need_bad;
    logic [31:0] rx;
    logic [31:0] rnd_rx;
    logic        is_array;

    assign in_ready = !req_valid_reg || out_ready;

    assign rnd_size  = round_al(in_mul.size);
    assign rnd_prod  = round_al(in_mul.prod);
    assign rnd_need  = round_al(in_mul.need[31:0]);
    assign align_m1  = in_mul.alignment - 32'd1;
    assign bad_size  = size_bad(in_mul.size);
    assign pow2      = (in_mul.alignment != '0) && ((in_mul.alignment & align_m1) == '0);
    assign aa_ok     = (in_mul.alignment != '0)
                       && (((in_mul.alignment | in_mul.size) & align_m1) == '0);
    assign big_align = in_mul.alignment > 32'(ALIGN_BYTES);
    assign need_bad  = in_mul.need > {1'b0, bap_pkg::SIZE_CAP};
    assign is_array  = (in_mul.opcode == bap_pkg::OP_REALLOCARRAY);
    assign rx        = is_array ? in_mul.prod : in_mul.size;
    assign rnd_rx    = is_array ? rnd_prod : rnd_size;

    always_comb begin
        req_next.kind       = bap_pkg::REQ_FAIL;
        req_next.ptr        = in_mul.address;
        req_next.raw_size   = rx;
        req_next.alloc_sz   = rnd_size;
        req_next.tiny       = 1'b0;
        req_next.post_align = 1'b0;
        req_next.align_m1   = align_m1;
        req_next.good       = bad_size ? in_mul.size : rnd_size;
        case (in_mul.opcode)
            bap_pkg::OP_MALLOC: begin
                if (!bad_size) begin
                    req_next.kind = bap_pkg::REQ_ALLOC;
                end
            end
            bap_pkg::OP_MEMALIGN, bap_pkg::OP_ALIGNED_ALLOC: begin
                if (!bad_size && pow2 && !(big_align && need_bad)
                    && !(in_mul.opcode == bap_pkg::OP_ALIGNED_ALLOC && !aa_ok)) begin
                    req_next.kind       = bap_pkg::REQ_ALLOC;
                    req_next.post_align = big_align;
                    req_next.alloc_sz   = big_align ? rnd_need : rnd_size;
                end
            end
            bap_pkg::OP_FREE: begin
                req_next.kind = bap_pkg::REQ_FREE;
            end
            bap_pkg::OP_CALLOC: begin
                req_next.alloc_sz = rnd_prod;
                if (!in_mul.prod_ovf && !size_bad(in_mul.prod)) begin
                    req_next.kind = bap_pkg::REQ_ALLOC;
                end
            end
            bap_pkg::OP_REALLOC, bap_pkg::OP_REALLOCARRAY: begin
                req_next.alloc_sz = rnd_rx;
                req_next.tiny     = rx <= 32'(ALIGN_BYTES);
                if (!(is_array && in_mul.prod_ovf)) begin
                    if (in_mul.address == '0) begin
                        if (!size_bad(rx)) begin
                            req_next.kind = bap_pkg::REQ_ALLOC;
                        end
                    end else if (rx == '0) begin
                        req_next.kind = bap_pkg::REQ_FREE;
                    end else if (!size_bad(rx)) begin
                        req_next.kind = bap_pkg::REQ_REALLOC;
                    end
                end
            end
            bap_pkg::OP_GOOD_SIZE: begin
                req_next.kind = bap_pkg::REQ_SIZE;
            end
            default: begin
                req_next.kind = bap_pkg::REQ_FAIL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (in_ready) begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            req_reg <= req_next;
        end
    end

    assign out_valid = req_valid_reg;
    assign out_req   = req_reg;

endmodule

### rtl/core/bap_core.sv
// Allocator state, page grow logic and result register.
module bap_core #(
    parameter int PAGE_BYTES  = bap_pkg::PAGE_BYTES_DEF,
    parameter int ALIGN_BYTES = bap_pkg::ALIGN_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bap_pkg::cfg_wr_t  cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  bap_pkg::req_t     req,
    output logic              out_valid,
    input  logic              out_ready,
    output bap_pkg::result_t  result
);

    localparam int          PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int          NPW        = 33 - PAGE_SHIFT;
    localparam int          SW         = NPW + 1;
    localparam logic [31:0] AMASK      = 32'(ALIGN_BYTES - 1);

    logic [31:0]      free_start_reg, free_start_next;
    logic [31:0]      free_limit_reg, free_limit_next;
    logic [31:0]      last_block_reg, last_block_next;
    logic [15:0]      mem_pages_reg, mem_pages_next;
    logic [15:0]      max_pages_reg;
    bap_pkg::result_t result_reg, result_next;
    logic             out_valid_reg;

    logic             fire;
    logic             is_last;
    logic [31:0]      start0;
    logic [31:0]      sz;
    logic [31:0]      avail1, def1, base, limit_ext1, arena_limit, avail2, def2, limit_ext2;
    logic [NPW-1:0]   np1, np2;
    logic [SW-1:0]    sum1, sum2;
    logic             fit1, grow1_ok, ext1, fit2, grow2_ok;
    logic             a_ok;
    logic [31:0]      a_start, a_limit;
    logic [15:0]      a_pages;
    logic [31:0]      al_addr, al_end, copy_len;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign is_last = (req.ptr == last_block_reg);
    assign start0  = (req.kind == bap_pkg::REQ_REALLOC && is_last) ? req.ptr : free_start_reg;
    assign sz      = req.alloc_sz;

    // first attempt against the current arena
    assign avail1     = free_limit_reg - start0;
    assign fit1       = sz <= avail1;
    assign def1       = sz - avail1;
    assign np1        = NPW'(def1[31:PAGE_SHIFT]) + NPW'(|def1[PAGE_SHIFT-1:0]);
    assign sum1       = SW'(mem_pages_reg) + SW'(np1);
    assign grow1_ok   = sum1 <= SW'(max_pages_reg);
    assign base       = 32'(mem_pages_reg) << PAGE_SHIFT;
    assign ext1       = (base == free_limit_reg);
    assign limit_ext1 = free_limit_reg + (32'(np1) << PAGE_SHIFT);

    // new arena at old end of memory; it always abuts memory end, so grow extends
    assign arena_limit = 32'(sum1) << PAGE_SHIFT;
    assign avail2      = 32'(np1) << PAGE_SHIFT;
    assign fit2        = sz <= avail2;
    assign def2        = sz - avail2;
    assign np2         = NPW'(def2[31:PAGE_SHIFT]) + NPW'(|def2[PAGE_SHIFT-1:0]);
    assign sum2        = sum1 + SW'(np2);
    assign grow2_ok    = sum2 <= SW'(max_pages_reg);
    assign limit_ext2  = arena_limit + (32'(np2) << PAGE_SHIFT);

    always_comb begin
        a_ok    = 1'b1;
        a_start = start0;
        a_limit = free_limit_reg;
        a_pages = mem_pages_reg;
        if (!fit1) begin
            if (!grow1_ok) begin
                a_ok = 1'b0;
            end else if (ext1) begin
                a_limit = limit_ext1;
                a_pages = sum1[15:0];
            end else begin
                a_start = base;
                a_limit = arena_limit;
                a_pages = sum1[15:0];
                if (!fit2) begin
                    if (!grow2_ok) begin
                        a_ok = 1'b0;
                    end else begin
                        a_limit = limit_ext2;
                        a_pages = sum2[15:0];
                    end
                end
            end
        end
    end

    assign al_addr  = (a_start + req.align_m1) & ~req.align_m1;
    assign al_end   = (al_addr + req.raw_size + AMASK) & ~AMASK;
    assign copy_len = free_start_reg - req.ptr;

    always_comb begin
        free_start_next = free_start_reg;
        free_limit_next = free_limit_reg;
        last_block_next = last_block_reg;
        mem_pages_next  = mem_pages_reg;
        result_next.result_addr = '0;
        result_next.is_null     = 1'b1;
        result_next.copy_source = '0;
        result_next.copy_length = '0;
        case (req.kind)
            bap_pkg::REQ_SIZE: begin
                result_next.result_addr = req.good;
                result_next.is_null     = 1'b0;
            end
            bap_pkg::REQ_FREE: begin
                if (req.ptr != '0 && is_last) begin
                    free_start_next = req.ptr;
                    last_block_next = '0;
                end
            end
            bap_pkg::REQ_ALLOC: begin
                free_start_next = a_start;
                free_limit_next = a_limit;
                mem_pages_next  = a_pages;
                if (a_ok) begin
                    if (req.post_align) begin
                        result_next.result_addr = al_addr;
                        free_start_next         = al_end;
                        last_block_next         = al_addr;
                    end else begin
                        result_next.result_addr = a_start;
                        free_start_next         = a_start + sz;
                        last_block_next         = a_start;
                    end
                    result_next.is_null = (result_next.result_addr == '0);
                end
            end
            bap_pkg::REQ_REALLOC: begin
                if (req.tiny && !is_last) begin
                    result_next.result_addr = req.ptr;
                    result_next.is_null     = 1'b0;
                end else begin
                    free_limit_next = a_limit;
                    mem_pages_next  = a_pages;
                    if (a_ok) begin
                        result_next.result_addr = a_start;
                        result_next.is_null     = (a_start == '0);
                        free_start_next         = a_start + sz;
                        last_block_next         = a_start;
                        if (a_start != req.ptr) begin
                            result_next.copy_source = req.ptr;
                            result_next.copy_length =
                                (copy_len > req.raw_size) ? req.raw_size : copy_len;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_start_reg <= bap_pkg::HEAP_START_RST;
            free_limit_reg <= bap_pkg::HEAP_LIMIT_RST;
            last_block_reg <= '0;
            mem_pages_reg  <= bap_pkg::INIT_PAGES_RST;
            max_pages_reg  <= bap_pkg::MAX_PAGES_RST;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (fire) begin
                free_start_reg <= free_start_next;
                free_limit_reg <= free_limit_next;
                last_block_reg <= last_block_next;
                mem_pages_reg  <= mem_pages_next;
            end
            if (cfg.en) begin
                case (cfg.index)
                    bap_pkg::CFG_HEAP_START: free_start_reg <= cfg.data;
                    bap_pkg::CFG_HEAP_LIMIT: free_limit_reg <= cfg.data;
                    bap_pkg::CFG_INIT_PAGES: mem_pages_reg  <= cfg.data[15:0];
                    bap_pkg::CFG_MAX_PAGES:  max_pages_reg  <= cfg.data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // a grow never takes memory past the page limit
    a_pages_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !cfg.en && (mem_pages_next != mem_pages_reg)
        |-> mem_pages_next <= max_pages_reg)
        else $error("page count grew past max_pages");

    // a request rejected at decode leaves the allocator state untouched
    a_fail_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !cfg.en && req.kind == bap_pkg::REQ_FAIL
        |=> $stable(free_start_reg) && $stable(free_limit_reg)
            && $stable(last_block_reg) && $stable(mem_pages_reg))
        else $error("failed request changed allocator state");

    // good-size results are never flagged null
    a_size_not_null: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && req.kind == bap_pkg::REQ_SIZE |=> !result_reg.is_null)
        else $error("good-size result flagged null");

    // a copy is only reported with its source block
    a_copy_src: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.copy_length != '0 |-> result_reg.copy_source != '0)
        else $error("copy length without copy source");

endmodule

### rtl/core/bump_allocator_with_page_grow.sv
// Top level of the bump allocator with page-granular memory growth.
//
// Requests enter on the s_ stream channel, one item per handshake; each item
// produces exactly one result item on the m_ stream channel, in order.
// s_tuser carries the opcode; s_tdata carries address, size, count and
// alignment. m_tdata returns result_addr, copy_source and copy_length;
// m_tuser carries is_null.
// The result passes through the input register, multiply stage, decode
// stage and result register. Throughput: one item per cycle while m_tready
// stays high; the pointer and page registers are read and updated for each
// item by the allocation stage, which sets that rate. When m_tready is low
// the four stages keep filling; s_tready drops once all hold an item and
// returns as soon as the result is taken. Reset returns free start, free
// limit and page count to their reset values and empties the pipeline.
// Configuration writes load the matching state register directly; the user
// must make them only while no request is in flight, which is not enforced.
module bump_allocator_with_page_grow #(
    parameter int PAGE_BYTES  = bap_pkg::PAGE_BYTES_DEF,
    parameter int ALIGN_BYTES = bap_pkg::ALIGN_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // address, size, count, alignment
    input  logic [2:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // result_addr, copy_source, copy_length
    output logic         m_tuser    // is_null
);

    bap_pkg::item_t   in_item;
    bap_pkg::mul_t    mul;
    bap_pkg::req_t    req;
    bap_pkg::result_t result;
    bap_pkg::cfg_wr_t cfg;
    logic             mul_valid, mul_ready;
    logic             req_valid, req_ready;

    assign in_item.opcode    = bap_pkg::opcode_t'(s_tuser);
    assign in_item.address   = s_tdata[31:0];
    assign in_item.size      = s_tdata[63:32];
    assign in_item.count     = s_tdata[95:64];
    assign in_item.alignment = s_tdata[127:96];

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = bap_pkg::cfg_idx_t'(cfg_index);
    assign cfg.data  = cfg_wdata;

    bap_front #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_mul   (mul)
    );

    bap_prep #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_mul    (mul),
        .out_valid (req_valid),
        .out_ready (req_ready),
        .out_req   (req)
    );

    bap_core #(
        .PAGE_BYTES  (PAGE_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .req       (req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = {result.copy_length, result.copy_source, result.result_addr};
    assign m_tuser = result.is_null;

endmodule
